/* src/hbk_pkg.sv */
// ----------------------------------------------------------------------------
// hbk_pkg
// Shared codes and types for the boot keyboard event decoder.
// ----------------------------------------------------------------------------
package hbk_pkg;

    typedef logic [7:0] usage_t;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] FUNC_REPORT     = 2'd0;
    localparam logic [1:0] FUNC_TICK       = 2'd1;
    localparam logic [1:0] FUNC_DISCONNECT = 2'd2;

    // Event kinds carried on the output tuser.
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_HELD    = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_REPEAT_DELAY    = 1'b0;
    localparam logic CFG_REPEAT_INTERVAL = 1'b1;

    localparam usage_t ROLL_OVER_USAGE = 8'h01;
    localparam usage_t EMPTY_USAGE     = 8'h00;

    localparam logic [15:0] REPEAT_DELAY_RESET    = 16'd500;
    localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd50;

    // A pressed key that the sequencer asks the top level to store.
    typedef struct packed {
        logic   valid;
        usage_t usage;
    } hbk_alloc_t;

endpackage

/* src/hbk_lane.sv */
// ----------------------------------------------------------------------------
// hbk_lane
// One key lane: compares its held slot and its report key against the
// other side and flags a release, a new press and a roll-over marker.
// ----------------------------------------------------------------------------
module hbk_lane #(
    parameter int KEY_SLOTS = 6,
    parameter int LANE      = 0
) (
    input  logic [KEY_SLOTS-1:0][7:0] keys,
    input  logic [KEY_SLOTS-1:0][7:0] held,
    output logic                      rel_hit,
    output logic                      press_hit,
    output logic                      roll_hit
);
    import hbk_pkg::*;

    always_comb begin
        logic held_in_report;
        logic key_is_held;
        logic key_seen_before;
        held_in_report  = 1'b0;
        key_is_held     = 1'b0;
        key_seen_before = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (keys[j] == held[LANE]) begin
                held_in_report = 1'b1;
            end
            if (held[j] == keys[LANE]) begin
                key_is_held = 1'b1;
            end
            // An earlier copy of the same usage already takes the press.
            if (j < LANE && keys[j] == keys[LANE]) begin
                key_seen_before = 1'b1;
            end
        end
        rel_hit   = (held[LANE] != EMPTY_USAGE) && !held_in_report;
        press_hit = (keys[LANE] != EMPTY_USAGE) && !key_is_held && !key_seen_before;
        roll_hit  = (keys[LANE] == ROLL_OVER_USAGE);
    end

endmodule

/* src/hbk_seq.sv */
// ----------------------------------------------------------------------------
// hbk_seq
// Event sequencer: holds the merged lane masks and sends one event beat per
// cycle while the output is not stalled, releases first, then presses, then a held repeat.
// ----------------------------------------------------------------------------
module hbk_seq #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic [KEY_SLOTS-1:0]      load_rel,
    input  logic [KEY_SLOTS-1:0]      load_prs,
    input  logic                      load_hld,
    input  logic [KEY_SLOTS-1:0][7:0] load_rel_usage,
    input  logic [KEY_SLOTS-1:0][7:0] load_prs_usage,
    input  logic [7:0]                load_hld_usage,
    input  logic [3:0]                load_mods,
    input  logic [31:0]               load_time,
    output logic                      busy,
    output hbk_pkg::hbk_alloc_t       alloc,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [47:0]               m_tdata,  // key_usage, event_mods, event_time, 4'b0
    output logic [1:0]                m_tuser,  // event_kind
    output logic                      m_tlast
);
    import hbk_pkg::*;

    logic [KEY_SLOTS-1:0]      rel_reg, rel_next;
    logic [KEY_SLOTS-1:0]      prs_reg, prs_next;
    logic                      hld_reg, hld_next;
    logic [KEY_SLOTS-1:0][7:0] rel_usage_reg;
    logic [KEY_SLOTS-1:0][7:0] prs_usage_reg;
    logic [7:0]                hld_usage_reg;
    logic [3:0]                mods_reg;
    logic [31:0]               time_reg;

    logic                      out_valid_reg;
    logic [1:0]                out_kind_reg;
    logic [7:0]                out_usage_reg;
    logic [3:0]                out_mods_reg;
    logic [31:0]               out_time_reg;
    logic                      out_last_reg;

    logic                      fire;
    logic [1:0]                pick_kind;
    logic [7:0]                pick_usage;
    logic                      pick_last;

    assign busy = (|rel_reg) || (|prs_reg) || hld_reg;
    assign fire = busy && (!out_valid_reg || m_tready);

    always_comb begin
        logic [KEY_SLOTS-1:0] rel_low;
        logic [KEY_SLOTS-1:0] prs_low;
        rel_low    = rel_reg & (~rel_reg + 1'b1);
        prs_low    = prs_reg & (~prs_reg + 1'b1);
        rel_next   = rel_reg;
        prs_next   = prs_reg;
        hld_next   = hld_reg;
        pick_usage = '0;
        if (|rel_reg) begin
            pick_kind = EV_RELEASE;
            rel_next  = rel_reg & ~rel_low;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (rel_low[i]) begin
                    pick_usage = rel_usage_reg[i];
                end
            end
        end else if (|prs_reg) begin
            pick_kind = EV_PRESS;
            prs_next  = prs_reg & ~prs_low;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (prs_low[i]) begin
                    pick_usage = prs_usage_reg[i];
                end
            end
        end else begin
            pick_kind  = EV_HELD;
            pick_usage = hld_usage_reg;
            hld_next   = 1'b0;
        end
        pick_last = !(|rel_next) && !(|prs_next) && !hld_next;
    end

    assign alloc.valid = fire && !(|rel_reg) && (|prs_reg);
    assign alloc.usage = pick_usage;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_reg       <= '0;
            prs_reg       <= '0;
            hld_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                rel_reg <= load_rel;
                prs_reg <= load_prs;
                hld_reg <= load_hld;
            end else if (fire) begin
                rel_reg <= rel_next;
                prs_reg <= prs_next;
                hld_reg <= hld_next;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rel_usage_reg <= load_rel_usage;
            prs_usage_reg <= load_prs_usage;
            hld_usage_reg <= load_hld_usage;
            mods_reg      <= load_mods;
            time_reg      <= load_time;
        end
        if (fire) begin
            out_kind_reg  <= pick_kind;
            out_usage_reg <= pick_usage;
            out_mods_reg  <= mods_reg;
            out_time_reg  <= time_reg;
            out_last_reg  <= pick_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_time_reg, out_mods_reg, out_usage_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* src/hid_boot_keyboard_event_decoder.sv */
// ----------------------------------------------------------------------------
// hid_boot_keyboard_event_decoder
// Turns boot-protocol keyboard reports, ticks and disconnects into key events.
// ----------------------------------------------------------------------------
// The input beat is registered, evaluated in ST_EVAL and loaded into the sequencer, which registers each event beat.
// Throughput: one item at a time; an item gives at most 12 events, and the next
// item is taken only once the sequencer holds no more events to send.
// Reset (synchronous, active low) empties the held slots, clears modifiers,
// repeat key, deadline and time, and loads delay 500 and interval 50.
module hid_boot_keyboard_event_decoder #(
    parameter int KEY_SLOTS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // modifier_bits, key_0 .. key_5, now_ms
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // key_usage, event_mods, event_time, 4'b0
    output logic [1:0]  m_tuser,   // event_kind
    output logic        m_tlast
);
    import hbk_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [15:0]               delay_reg;
    logic [15:0]               interval_reg;

    logic [1:0]                func_reg;
    logic [7:0]                raw_mods_reg;
    logic [KEY_SLOTS-1:0][7:0] keys_reg;
    logic [31:0]               now_reg;

    logic [KEY_SLOTS-1:0][7:0] held_reg, held_next;
    logic [3:0]                mods_reg, mods_next;
    logic [7:0]                repeat_reg, repeat_next;
    logic [31:0]               deadline_reg, deadline_next;
    logic [31:0]               seen_reg, seen_next;

    logic [KEY_SLOTS-1:0]      lane_rel;
    logic [KEY_SLOTS-1:0]      lane_prs;
    logic [KEY_SLOTS-1:0]      lane_roll;

    logic                      seq_load;
    logic [KEY_SLOTS-1:0]      seq_rel;
    logic [KEY_SLOTS-1:0]      seq_prs;
    logic                      seq_hld;
    logic [3:0]                seq_mods;
    logic [31:0]               seq_time;
    logic                      seq_busy;
    hbk_alloc_t                seq_alloc;

    logic                      in_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
        hbk_lane #(
            .KEY_SLOTS (KEY_SLOTS),
            .LANE      (g)
        ) u_lane (
            .keys      (keys_reg),
            .held      (held_reg),
            .rel_hit   (lane_rel[g]),
            .press_hit (lane_prs[g]),
            .roll_hit  (lane_roll[g])
        );
    end

    // Merge stage: combines the lane flags into state updates and event masks.
    always_comb begin
        logic                 report_ok;
        logic                 repeat_gone;
        logic [7:0]           last_press;
        logic [31:0]          since;
        logic [KEY_SLOTS-1:0] occupied;
        logic [KEY_SLOTS-1:0] free;
        logic [KEY_SLOTS-1:0] first_free;

        state_next    = state_reg;
        held_next     = held_reg;
        mods_next     = mods_reg;
        repeat_next   = repeat_reg;
        deadline_next = deadline_reg;
        seen_next     = seen_reg;
        seq_load      = 1'b0;
        seq_rel       = '0;
        seq_prs       = '0;
        seq_hld       = 1'b0;
        seq_mods      = mods_reg;
        seq_time      = now_reg;

        report_ok   = (func_reg == FUNC_REPORT) && !(&lane_roll);
        repeat_gone = 1'b0;
        last_press  = EMPTY_USAGE;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            occupied[i] = (held_reg[i] != EMPTY_USAGE);
            free[i]     = !occupied[i];
            if (lane_rel[i] && held_reg[i] == repeat_reg) begin
                repeat_gone = 1'b1;
            end
            if (lane_prs[i]) begin
                last_press = keys_reg[i];
            end
        end
        first_free = free & (~free + 1'b1);
        since      = now_reg - deadline_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                seq_load   = 1'b1;
                state_next = ST_EMIT;
                case (func_reg)
                    FUNC_REPORT: begin
                        if (report_ok) begin
                            seen_next = now_reg;
                            mods_next = raw_mods_reg[3:0] | raw_mods_reg[7:4];
                            seq_mods  = raw_mods_reg[3:0] | raw_mods_reg[7:4];
                            seq_rel   = lane_rel;
                            seq_prs   = lane_prs;
                            for (int i = 0; i < KEY_SLOTS; i++) begin
                                if (lane_rel[i]) begin
                                    held_next[i] = EMPTY_USAGE;
                                end
                            end
                            if (|lane_prs) begin
                                repeat_next   = last_press;
                                deadline_next = now_reg + {16'd0, delay_reg};
                            end else if (repeat_gone) begin
                                repeat_next = EMPTY_USAGE;
                            end
                        end
                    end
                    FUNC_TICK: begin
                        seen_next = now_reg;
                        // Due once the wrapped difference is no longer negative.
                        if (repeat_reg != EMPTY_USAGE && !since[31]) begin
                            seq_hld       = 1'b1;
                            deadline_next = now_reg + {16'd0, interval_reg};
                        end
                    end
                    FUNC_DISCONNECT: begin
                        seq_rel       = occupied;
                        seq_time      = seen_reg;
                        held_next     = '0;
                        mods_next     = 4'd0;
                        repeat_next   = EMPTY_USAGE;
                        deadline_next = 32'd0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_EMIT: begin
                // Released slots were cleared already, so presses fill them.
                if (seq_alloc.valid) begin
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (first_free[i]) begin
                            held_next[i] = seq_alloc.usage;
                        end
                    end
                end
                if (!seq_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    hbk_seq #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (seq_load),
        .load_rel       (seq_rel),
        .load_prs       (seq_prs),
        .load_hld       (seq_hld),
        .load_rel_usage (held_reg),
        .load_prs_usage (keys_reg),
        .load_hld_usage (repeat_reg),
        .load_mods      (seq_mods),
        .load_time      (seq_time),
        .busy           (seq_busy),
        .alloc          (seq_alloc),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            delay_reg    <= REPEAT_DELAY_RESET;
            interval_reg <= REPEAT_INTERVAL_RESET;
            held_reg     <= '0;
            mods_reg     <= 4'd0;
            repeat_reg   <= EMPTY_USAGE;
            deadline_reg <= 32'd0;
            seen_reg     <= 32'd0;
        end else begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            mods_reg     <= mods_next;
            repeat_reg   <= repeat_next;
            deadline_reg <= deadline_next;
            seen_reg     <= seen_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_REPEAT_DELAY:    delay_reg    <= cfg_wdata;
                    CFG_REPEAT_INTERVAL: interval_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func_reg     <= s_tuser;
            raw_mods_reg <= s_tdata[7:0];
            now_reg      <= s_tdata[87:56];
            for (int i = 0; i < KEY_SLOTS; i++) begin
                keys_reg[i] <= s_tdata[8 + 8*i +: 8];
            end
        end
    end

endmodule
